/* hw/rtl/qdc_pkg.sv */
// Package for the quadrature decoder counter: widths, mode and mark codes,
// and the three decode transition tables with their lookup function.
// Depends on nothing; imported by the core and by its checker.
package qdc_pkg;

    localparam int COUNT_W = 32;
    localparam int STEP_W  = 2;
    localparam int MODE_W  = 3;
    localparam int STATE_W = 3;
    localparam int MARK_W  = 2;
    localparam int ENTRY_W = MARK_W + STATE_W;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REG_COUNT_MODE  = 2'd0;
    localparam logic [1:0] REG_MIN_LIMIT   = 2'd1;
    localparam logic [1:0] REG_MAX_LIMIT   = 2'd2;
    localparam logic [1:0] REG_WRAP_ENABLE = 2'd3;

    localparam logic [MODE_W-1:0] MODE_QUARTER     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_QUARTER_INV = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HALF        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALF_ALT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FULL        = 3'd4;

    localparam logic [1:0] INV_NONE = 2'b00;
    localparam logic [1:0] INV_BOTH = 2'b11;
    localparam logic [1:0] INV_B    = 2'b01;

    localparam logic [MARK_W-1:0] MK_NONE = 2'd0;
    localparam logic [MARK_W-1:0] MK_UP   = 2'd1;
    localparam logic [MARK_W-1:0] MK_DN   = 2'd2;
    localparam logic [MARK_W-1:0] MK_ERR  = 2'd3;

    localparam logic [STATE_W-1:0] ST_A   = 3'd0;
    localparam logic [STATE_W-1:0] ST_BCW = 3'd1;
    localparam logic [STATE_W-1:0] ST_DCW = 3'd2;
    localparam logic [STATE_W-1:0] ST_CCW = 3'd3;
    localparam logic [STATE_W-1:0] ST_BCC = 3'd4;
    localparam logic [STATE_W-1:0] ST_DCC = 3'd5;
    localparam logic [STATE_W-1:0] ST_CCC = 3'd6;

    localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
    localparam logic signed [STEP_W-1:0] STEP_UP   = 2'sb01;
    localparam logic signed [STEP_W-1:0] STEP_DN   = 2'sb11;

    typedef logic [ENTRY_W-1:0] t_entry;

    localparam t_entry TBL_QUARTER [0:31] = '{
        {MK_NONE, ST_A},   {MK_NONE, ST_BCW}, {MK_NONE, ST_DCC}, {MK_ERR, ST_A},
        {MK_NONE, ST_A},   {MK_NONE, ST_BCW}, {MK_ERR, ST_BCW},  {MK_NONE, ST_CCW},
        {MK_UP, ST_A},     {MK_ERR, ST_DCW},  {MK_NONE, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_ERR, ST_CCW},  {MK_NONE, ST_BCW}, {MK_NONE, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_DN, ST_A},     {MK_NONE, ST_BCC}, {MK_ERR, ST_BCC},  {MK_NONE, ST_CCC},
        {MK_NONE, ST_A},   {MK_ERR, ST_DCC},  {MK_NONE, ST_DCC}, {MK_NONE, ST_CCC},
        {MK_ERR, ST_CCC},  {MK_NONE, ST_BCC}, {MK_NONE, ST_DCC}, {MK_NONE, ST_CCC},
        {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A}
    };

    localparam t_entry TBL_HALF [0:31] = '{
        {MK_NONE, ST_A},   {MK_NONE, ST_BCW}, {MK_NONE, ST_DCC}, {MK_ERR, ST_A},
        {MK_NONE, ST_A},   {MK_NONE, ST_BCW}, {MK_ERR, ST_BCW},  {MK_UP, ST_CCW},
        {MK_UP, ST_A},     {MK_ERR, ST_DCW},  {MK_NONE, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_ERR, ST_CCW},  {MK_NONE, ST_BCC}, {MK_NONE, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_DN, ST_A},     {MK_NONE, ST_BCC}, {MK_ERR, ST_BCC},  {MK_NONE, ST_CCW},
        {MK_NONE, ST_A},   {MK_ERR, ST_BCC},  {MK_NONE, ST_DCC}, {MK_DN, ST_CCW},
        {MK_ERR, ST_CCC},  {MK_ERR, ST_CCC},  {MK_ERR, ST_CCC},  {MK_ERR, ST_CCC},
        {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A}
    };

    localparam t_entry TBL_FULL [0:31] = '{
        {MK_NONE, ST_A},   {MK_UP, ST_BCW},   {MK_DN, ST_DCW},   {MK_ERR, ST_A},
        {MK_DN, ST_A},     {MK_NONE, ST_BCW}, {MK_ERR, ST_BCW},  {MK_UP, ST_CCW},
        {MK_UP, ST_A},     {MK_ERR, ST_DCW},  {MK_NONE, ST_DCW}, {MK_DN, ST_CCW},
        {MK_ERR, ST_CCW},  {MK_DN, ST_BCW},   {MK_UP, ST_DCW},   {MK_NONE, ST_CCW},
        {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},
        {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},
        {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},
        {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A},   {MK_NONE, ST_A}
    };

    function automatic t_entry qdc_lookup(input logic [MODE_W-1:0] mode,
                                          input logic [STATE_W-1:0] row,
                                          input logic [1:0] code);
        logic [4:0] idx;
        t_entry     entry;
        idx = {row, code};
        case (mode) inside
            MODE_QUARTER, MODE_QUARTER_INV: entry = TBL_QUARTER[idx];
            MODE_HALF, MODE_HALF_ALT:       entry = TBL_HALF[idx];
            default:                        entry = TBL_FULL[idx];
        endcase
        return entry;
    endfunction

    function automatic logic [1:0] qdc_invert(input logic [MODE_W-1:0] mode);
        logic [1:0] inv;
        case (mode)
            MODE_QUARTER:  inv = INV_BOTH;
            MODE_HALF_ALT: inv = INV_B;
            default:       inv = INV_NONE;
        endcase
        return inv;
    endfunction

endpackage

/* hw/rtl/quadrature_decoder_counter_core.sv */
// A beat is taken into the input stage, then moved into the result registers.
// Throughput: one beat per cycle when not stalled; the input stage holds a beat
// while a result waits, so the input side accepts until both stages are full.
// The decode state and the count are updated when a beat leaves the input stage.
// Reset (synchronous, active low) empties both stages, clears the decode state
// and the count, and loads the configuration registers with their defaults.
module quadrature_decoder_counter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic                                i_phase_a,
    input  logic                                i_phase_b,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [qdc_pkg::STEP_W-1:0]   o_step,
    output logic signed [qdc_pkg::COUNT_W-1:0]  o_count,
    output logic                                o_error_flag,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qdc_pkg::ADDR_W-1:0]          paddr,
    input  logic [qdc_pkg::DATA_W-1:0]          pwdata,
    output logic [qdc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import qdc_pkg::*;

    logic [MODE_W-1:0]         r_count_mode;
    logic signed [COUNT_W-1:0] r_min_limit;
    logic signed [COUNT_W-1:0] r_max_limit;
    logic                      r_wrap_enable;

    logic                      r_in_valid;
    logic                      r_cmd;
    logic                      r_phase_a;
    logic                      r_phase_b;

    logic [STATE_W-1:0]        r_decode_state;
    logic signed [COUNT_W-1:0] r_count;

    logic                      r_out_valid;
    logic signed [STEP_W-1:0]  r_step;
    logic                      r_error_flag;

    logic                      advance;
    logic                      wr_en;
    logic [1:0]                reg_idx;
    logic [1:0]                code;
    logic signed [COUNT_W-1:0] lo;
    logic signed [COUNT_W-1:0] hi;
    t_entry                    entry;
    logic [MARK_W-1:0]         mark;
    logic [STATE_W-1:0]        n_decode_state;
    logic signed [COUNT_W-1:0] n_count;
    logic signed [STEP_W-1:0]  n_step;
    logic                      n_error_flag;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign wr_en      = psel && penable && pwrite;
    assign reg_idx    = paddr[ADDR_W-1:2];
    assign pready     = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_COUNT_MODE:  prdata = {{(DATA_W-MODE_W){1'b0}}, r_count_mode};
            REG_MIN_LIMIT:   prdata = r_min_limit;
            REG_MAX_LIMIT:   prdata = r_max_limit;
            REG_WRAP_ENABLE: prdata = {{(DATA_W-1){1'b0}}, r_wrap_enable};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        code  = {r_phase_a, r_phase_b} ^ qdc_invert(r_count_mode);
        entry = qdc_lookup(r_count_mode, r_decode_state, code);
        mark  = entry[ENTRY_W-1:STATE_W];
        if (r_min_limit >= r_max_limit) begin
            lo = {1'b1, {(COUNT_W-1){1'b0}}};
            hi = {1'b0, {(COUNT_W-1){1'b1}}};
        end else begin
            lo = r_min_limit;
            hi = r_max_limit;
        end
        n_decode_state = entry[STATE_W-1:0];
        n_count        = r_count;
        n_step         = STEP_NONE;
        n_error_flag   = 1'b0;
        if (r_cmd) begin
            n_decode_state = {1'b0, code};
        end else begin
            case (mark)
                MK_UP: begin
                    if (r_count < hi) begin
                        n_count = r_count + 32'sd1;
                        n_step  = STEP_UP;
                    end else if (r_wrap_enable) begin
                        n_count = lo;
                        n_step  = STEP_UP;
                    end else begin
                        n_count = hi;
                    end
                end
                MK_DN: begin
                    if (r_count > lo) begin
                        n_count = r_count - 32'sd1;
                        n_step  = STEP_DN;
                    end else if (r_wrap_enable) begin
                        n_count = hi;
                        n_step  = STEP_DN;
                    end else begin
                        n_count = lo;
                    end
                end
                MK_ERR: begin
                    n_error_flag = 1'b1;
                end
                default: begin
                    n_error_flag = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode   <= MODE_FULL;
            r_min_limit    <= {1'b1, {(COUNT_W-1){1'b0}}};
            r_max_limit    <= {1'b0, {(COUNT_W-1){1'b1}}};
            r_wrap_enable  <= 1'b0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_decode_state <= ST_A;
            r_count        <= '0;
        end else begin
            if (wr_en) begin
                case (reg_idx)
                    REG_COUNT_MODE:  r_count_mode  <= pwdata[MODE_W-1:0];
                    REG_MIN_LIMIT:   r_min_limit   <= pwdata;
                    REG_MAX_LIMIT:   r_max_limit   <= pwdata;
                    REG_WRAP_ENABLE: r_wrap_enable <= pwdata[0];
                    default:         r_wrap_enable <= r_wrap_enable;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_decode_state <= n_decode_state;
                    r_count        <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd     <= i_cmd;
            r_phase_a <= i_phase_a;
            r_phase_b <= i_phase_b;
        end
        if (advance && r_in_valid) begin
            r_step       <= n_step;
            r_error_flag <= n_error_flag;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_step       = r_step;
    assign o_count      = r_count;
    assign o_error_flag = r_error_flag;

endmodule

/* hw/rtl/qdc_checker.sv */
// Port-level checker for the quadrature decoder counter core, with its bind.
// Depends on qdc_pkg for widths and step codes.
module qdc_port_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [qdc_pkg::STEP_W-1:0]  o_step,
    input logic signed [qdc_pkg::COUNT_W-1:0] o_count,
    input logic                               o_error_flag
);
    import qdc_pkg::*;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_count)
            && $stable(o_step) && $stable(o_error_flag))
        else $error("Stalled result changed.");

    a_error_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_flag |-> o_step == STEP_NONE)
        else $error("Error beat moved the count.");

    a_step_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_step == STEP_NONE || o_step == STEP_UP || o_step == STEP_DN))
        else $error("Illegal step code.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled with no result pending.");

endmodule

bind quadrature_decoder_counter_core qdc_port_checker u_qdc_checker (.*);

/* tb/qdc_checker.sv */
// Checker for the quadrature decoder counter: watches the input, result and
// register ports, predicts every result beat and compares it field by field.
// Depends on qdc_pkg for widths and codes; instantiated by tb_top.
`timescale 1ns / 100ps

module qdc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_cmd,
    input  logic                               i_phase_a,
    input  logic                               i_phase_b,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [qdc_pkg::STEP_W-1:0]  i_step,
    input  logic signed [qdc_pkg::COUNT_W-1:0] i_count,
    input  logic                               i_error_flag,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [qdc_pkg::ADDR_W-1:0]         i_paddr,
    input  logic [qdc_pkg::DATA_W-1:0]         i_pwdata,
    input  logic                               i_pready,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import qdc_pkg::*;

    typedef struct packed {
        logic signed [STEP_W-1:0]  step;
        logic signed [COUNT_W-1:0] count;
        logic                      err;
    } t_result;

    localparam logic signed [COUNT_W-1:0] COUNT_FLOOR = 32'sh8000_0000;
    localparam logic signed [COUNT_W-1:0] COUNT_CEIL  = 32'sh7FFF_FFFF;

    // Each entry is {mark, next state}, indexed by {decode state, phase code}.
    localparam logic [4:0] QTR_MOVES [0:31] = '{
        {MK_NONE, ST_A}, {MK_NONE, ST_BCW}, {MK_NONE, ST_DCC}, {MK_ERR, ST_A},
        {MK_NONE, ST_A}, {MK_NONE, ST_BCW}, {MK_ERR, ST_BCW}, {MK_NONE, ST_CCW},
        {MK_UP, ST_A}, {MK_ERR, ST_DCW}, {MK_NONE, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_ERR, ST_CCW}, {MK_NONE, ST_BCW}, {MK_NONE, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_DN, ST_A}, {MK_NONE, ST_BCC}, {MK_ERR, ST_BCC}, {MK_NONE, ST_CCC},
        {MK_NONE, ST_A}, {MK_ERR, ST_DCC}, {MK_NONE, ST_DCC}, {MK_NONE, ST_CCC},
        {MK_ERR, ST_CCC}, {MK_NONE, ST_BCC}, {MK_NONE, ST_DCC}, {MK_NONE, ST_CCC},
        {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}
    };

    localparam logic [4:0] HALF_MOVES [0:31] = '{
        {MK_NONE, ST_A}, {MK_NONE, ST_BCW}, {MK_NONE, ST_DCC}, {MK_ERR, ST_A},
        {MK_NONE, ST_A}, {MK_NONE, ST_BCW}, {MK_ERR, ST_BCW}, {MK_UP, ST_CCW},
        {MK_UP, ST_A}, {MK_ERR, ST_DCW}, {MK_NONE, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_ERR, ST_CCW}, {MK_NONE, ST_BCC}, {MK_NONE, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_DN, ST_A}, {MK_NONE, ST_BCC}, {MK_ERR, ST_BCC}, {MK_NONE, ST_CCW},
        {MK_NONE, ST_A}, {MK_ERR, ST_BCC}, {MK_NONE, ST_DCC}, {MK_DN, ST_CCW},
        {MK_ERR, ST_CCC}, {MK_ERR, ST_CCC}, {MK_ERR, ST_CCC}, {MK_ERR, ST_CCC},
        {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}
    };

    localparam logic [4:0] FULL_MOVES [0:31] = '{
        {MK_NONE, ST_A}, {MK_UP, ST_BCW}, {MK_DN, ST_DCW}, {MK_ERR, ST_A},
        {MK_DN, ST_A}, {MK_NONE, ST_BCW}, {MK_ERR, ST_BCW}, {MK_UP, ST_CCW},
        {MK_UP, ST_A}, {MK_ERR, ST_DCW}, {MK_NONE, ST_DCW}, {MK_DN, ST_CCW},
        {MK_ERR, ST_CCW}, {MK_DN, ST_BCW}, {MK_UP, ST_DCW}, {MK_NONE, ST_CCW},
        {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A},
        {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A},
        {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A},
        {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}, {MK_NONE, ST_A}
    };

    logic [MODE_W-1:0]         cfg_mode;
    logic signed [COUNT_W-1:0] cfg_min;
    logic signed [COUNT_W-1:0] cfg_max;
    logic                      cfg_wrap;
    logic [STATE_W-1:0]        dec_state;
    logic signed [COUNT_W-1:0] position;
    t_result                   expected_counts [$];

    function automatic logic [1:0] phase_flip(input logic [MODE_W-1:0] mode);
        case (mode)
            MODE_QUARTER:  return INV_BOTH;
            MODE_HALF_ALT: return INV_B;
            default:       return INV_NONE;
        endcase
    endfunction

    task automatic track_encoder(input logic cmd, input logic pa, input logic pb);
        logic [1:0]                code;
        logic [4:0]                move;
        logic signed [COUNT_W-1:0] lo;
        logic signed [COUNT_W-1:0] hi;
        t_result                   res;
        code = {pa, pb} ^ phase_flip(cfg_mode);
        lo = cfg_min;
        hi = cfg_max;
        if (lo >= hi) begin
            lo = COUNT_FLOOR;
            hi = COUNT_CEIL;
        end
        res.step = STEP_NONE;
        res.err = 1'b0;
        if (cmd) begin
            dec_state = {1'b0, code};
        end else begin
            case (cfg_mode)
                MODE_QUARTER, MODE_QUARTER_INV: move = QTR_MOVES[{dec_state, code}];
                MODE_HALF, MODE_HALF_ALT:       move = HALF_MOVES[{dec_state, code}];
                default:                        move = FULL_MOVES[{dec_state, code}];
            endcase
            dec_state = move[STATE_W-1:0];
            case (move[4:3])
                MK_UP: begin
                    if (position < hi) begin
                        position = position + 1;
                        res.step = STEP_UP;
                    end else if (cfg_wrap) begin
                        position = lo;
                        res.step = STEP_UP;
                    end else begin
                        position = hi;
                    end
                end
                MK_DN: begin
                    if (position > lo) begin
                        position = position - 1;
                        res.step = STEP_DN;
                    end else if (cfg_wrap) begin
                        position = hi;
                        res.step = STEP_DN;
                    end else begin
                        position = lo;
                    end
                end
                MK_ERR: res.err = 1'b1;
                default: ;
            endcase
        end
        res.count = position;
        expected_counts.push_back(res);
    endtask

    task automatic flag_fault(input string what, input t_result want);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t %s: expected step %0d count %0d error %0b,",
                     $realtime, what, $signed(want.step), $signed(want.count), want.err,
                     " got step %0d count %0d error %0b",
                     i_step, i_count, i_error_flag);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            cfg_mode = MODE_FULL;
            cfg_min = COUNT_FLOOR;
            cfg_max = COUNT_CEIL;
            cfg_wrap = 1'b0;
            dec_state = ST_A;
            position = '0;
            expected_counts.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_counts.size() == 0) begin
                    want = '0;
                    flag_fault("result beat with nothing expected", want);
                end else begin
                    want = expected_counts.pop_front();
                    if (i_step !== want.step || i_count !== want.count ||
                        i_error_flag !== want.err) begin
                        flag_fault("result mismatch", want);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                track_encoder(i_cmd, i_phase_a, i_phase_b);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_COUNT_MODE:  cfg_mode = i_pwdata[MODE_W-1:0];
                    REG_MIN_LIMIT:   cfg_min = i_pwdata;
                    REG_MAX_LIMIT:   cfg_max = i_pwdata;
                    REG_WRAP_ENABLE: cfg_wrap = i_pwdata[0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_counts.size();
    end

endmodule

/* tb/tb_top.sv */
// Top of the quadrature decoder counter testbench: clock, reset, encoder
// walks with bursts and gaps, a stalling result receiver and register setup.
// Depends on qdc_pkg, quadrature_decoder_counter_core and qdc_checker.
`timescale 1ns / 100ps

module tb_top;
    import qdc_pkg::*;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      i_cmd = 1'b0;
    logic                      i_phase_a = 1'b0;
    logic                      i_phase_b = 1'b0;
    logic                      i_out_ready = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [STEP_W-1:0]  o_step;
    logic signed [COUNT_W-1:0] o_count;
    logic                      o_error_flag;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    int                        fail_count;
    int                        pending;

    bit                        long_hold_req = 1'b0;
    logic [1:0]                pos = 2'd0;
    logic [1:0]                heading = 2'b01;
    int                        burst_left = 1;

    quadrature_decoder_counter_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_phase_a    (i_phase_a),
        .i_phase_b    (i_phase_b),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_step       (o_step),
        .o_count      (o_count),
        .o_error_flag (o_error_flag),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    qdc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_phase_a    (i_phase_a),
        .i_phase_b    (i_phase_b),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_step       (o_step),
        .i_count      (o_count),
        .i_error_flag (o_error_flag),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result receiver: stall segments of varying density, plus one long
    // hold-off on request so that both pipeline stages fill up.
    initial begin
        int seg_left;
        int seg_kind;
        seg_left = 0;
        seg_kind = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_kind = $urandom_range(0, 2);
                    seg_left = $urandom_range(1, 40);
                end
                seg_left--;
                case (seg_kind)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic pa, input logic pb);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_phase_a <= pa;
        i_phase_b <= pb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Sends the current encoder position as a Gray-coded phase pair.
    task automatic issue(input logic cmd);
        send_beat(cmd, pos[1], pos[1] ^ pos[0]);
        burst_left--;
        if (burst_left <= 0) begin
            idle_cycles($urandom_range(1, 10));
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic turn(input logic [1:0] dir, input int n);
        repeat (n) begin
            pos = pos + dir;
            issue(1'b0);
        end
    endtask

    task automatic settle();
        idle_cycles(1);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input int ph);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [MODE_W-1:0] mode;
        case (ph % 6)
            0: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            1: begin
                lo = -$urandom_range(0, 8);
                hi = $urandom_range(0, 8);
            end
            2: begin
                hi = 32'h7FFF_FFFF;
                lo = hi - $urandom_range(1, 6);
            end
            3: begin
                lo = 32'h8000_0000;
                hi = lo + $urandom_range(1, 6);
            end
            4: begin
                lo = $urandom_range(0, 100);
                hi = lo - $urandom_range(0, 5);
            end
            default: begin
                lo = $urandom;
                hi = lo + $urandom_range(1, 10);
            end
        endcase
        mode = (ph < 8) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 4));
        reg_write(REG_COUNT_MODE, {{(DATA_W-MODE_W){1'b0}}, mode});
        reg_write(REG_MIN_LIMIT, lo);
        reg_write(REG_MAX_LIMIT, hi);
        reg_write(REG_WRAP_ENABLE, {{(DATA_W-1){1'b0}}, 1'((ph + ph / 6) % 2)});
    endtask

    // Mostly legal quadrature walks with dwell and reversals; the rest are
    // illegal jumps, sync commands and arbitrary samples.
    task automatic send_random();
        int   r;
        logic cmd;
        r = $urandom_range(0, 99);
        cmd = 1'b0;
        if (r < 10) begin
            cmd = 1'b0;
        end else if (r < 85) begin
            if ($urandom_range(0, 9) == 0) heading = -heading;
            pos = pos + heading;
        end else if (r < 91) begin
            pos = pos + 2'd2;
        end else if (r < 95) begin
            cmd = 1'b1;
            pos = 2'($urandom_range(0, 3));
        end else begin
            pos = 2'($urandom_range(0, 3));
        end
        issue(cmd);
    endtask

    initial begin
        int ph;
        int k;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(1'b0);
        turn(2'b01, 4);
        turn(2'b11, 4);
        pos = pos + 2'd2;
        issue(1'b0);
        pos = 2'd2;
        issue(1'b1);
        pos = 2'd0;
        issue(1'b1);

        settle();
        reg_write(REG_MIN_LIMIT, 32'h7FFF_FFFD);
        reg_write(REG_MAX_LIMIT, 32'h7FFF_FFFF);
        turn(2'b11, 1);
        turn(2'b01, 4);
        settle();
        reg_write(REG_WRAP_ENABLE, 32'd1);
        turn(2'b01, 1);
        settle();
        reg_write(REG_MIN_LIMIT, 32'd5);
        reg_write(REG_MAX_LIMIT, 32'd5);
        turn(2'b01, 3);
        turn(2'b11, 2);

        for (ph = 0; ph < 12; ph++) begin
            settle();
            configure(ph);
            for (k = 0; k < 167; k++) begin
                if (ph == 2 && k == 0) long_hold_req = 1'b1;
                if (ph == 5 && k == 83) settle();
                send_random();
            end
        end

        idle_cycles(1);
        wait (pending == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/qdc_pkg.sv
hw/rtl/quadrature_decoder_counter_core.sv
hw/rtl/qdc_checker.sv
tb/qdc_checker.sv
tb/tb_top.sv
